/* rtl/hnm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// hnm_pkg
// Shared types and constants of the height map to normal map filter.
// ---------------------------------------------------------------------------
package hnm_pkg;

  // line store geometry
  localparam int MAX_WIDTH  = 2048;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int WIDTH_W    = 12;

  // datapath widths
  localparam int HEIGHT_W   = 16;
  localparam int STRENGTH_W = 16;
  localparam int DIFF_W     = HEIGHT_W + 1;
  localparam int PROD_W     = HEIGHT_W + STRENGTH_W;
  localparam int COMP_W     = 23;
  localparam int SQ_W       = 2 * COMP_W;
  localparam int LEN4_W     = SQ_W + 4;
  localparam int REM_W      = 64;
  localparam int TRIAL_W    = REM_W + 2;
  localparam int J_W        = 7;
  localparam int YACC_W     = LEN4_W + J_W;
  localparam int SH_W       = 4;
  localparam int CODE_W     = 8;
  localparam int NUM_LANES  = 3;

  // z component of the vector, scaled by 512 * 65535
  localparam logic [PROD_W-1:0] Z_UNIT    = 32'd33553920;
  localparam logic [SH_W-1:0]   MIN_SHIFT = 4'd2;
  localparam logic [CODE_W-1:0] CODE_MID  = 8'd128;

  // configuration
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_STRENGTH    = 1'b1;
  localparam logic [WIDTH_W-1:0]    WIDTH_RESET    = 12'd64;
  localparam logic [STRENGTH_W-1:0] STRENGTH_RESET = 16'd512;

  // operation codes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef struct packed {
    logic                operation;
    logic [HEIGHT_W-1:0] height_sample;
  } in_word_t;

  typedef struct packed {
    logic [CODE_W-1:0] red;
    logic [CODE_W-1:0] green;
    logic [CODE_W-1:0] blue;
    logic              row_end;
    logic              frame_end;
  } out_word_t;

  typedef struct packed {
    logic [HEIGHT_W-1:0] upper;
    logic [HEIGHT_W-1:0] center;
  } col_pair_t;

  typedef struct packed {
    logic row_end;
    logic frame_end;
  } side_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [YACC_W-1:0] yacc;
    logic [J_W-1:0]    j;
    logic              neg;
  } lane_t;

  typedef struct packed {
    lane_t [NUM_LANES-1:0] lane;
    logic [LEN4_W-1:0]     len4;
    side_t                 side;
  } iter_t;

endpackage

`default_nettype wire

/* rtl/heightmap_normal_map_filter_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// heightmap_normal_map_filter_unit
// Streaming height map to normal map filter with one row store of column pairs.
// ---------------------------------------------------------------------------
// Throughput: one word per cycle unless a held output word stalls the chain;
//   set by the single row-store read issued per accepted word (next column
//   prefetched) and the 14 register stages.
// Reset: synchronous, active low; clears column, row count, drain flag, the
//   pipeline valids and the config registers. The row store is not cleared.
// ---------------------------------------------------------------------------
module heightmap_normal_map_filter_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  hnm_pkg::in_word_t                   in_word,
  output logic                                out_valid,
  input  logic                                out_ready,
  output hnm_pkg::out_word_t                  out_word,
  input  logic                                cfg_wr_en,
  input  logic [hnm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hnm_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int LANES = hnm_pkg::NUM_LANES;

  // ---------------- configuration ----------------
  logic [hnm_pkg::WIDTH_W-1:0]    width_r;
  logic [hnm_pkg::STRENGTH_W-1:0] strength_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= hnm_pkg::WIDTH_RESET;
      strength_r <= hnm_pkg::STRENGTH_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        hnm_pkg::REG_IMAGE_WIDTH: width_r    <= cfg_data[hnm_pkg::WIDTH_W-1:0];
        hnm_pkg::REG_STRENGTH:    strength_r <= cfg_data;
      endcase
    end
  end

  // ---------------- pipeline advance ----------------
  // Every stage moves together; the output register frees the chain as soon
  // as its word is taken, so a new word enters every cycle unless out_ready stalls.
  logic adv;
  logic acc;
  logic out_valid_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;
  assign acc      = in_valid && in_ready;

  // ---------------- stage 0: scan control and row store ----------------
  // Each store entry holds the pair (row above, current row) of one column.
  // The pair of the column after the current one is prefetched into
  // rdata_r, so at accept rdata_r already holds the current column, and once
  // the word is accepted it holds the right neighbor.
  hnm_pkg::col_pair_t mem [hnm_pkg::MAX_WIDTH];
  hnm_pkg::col_pair_t rdata_r;

  logic [hnm_pkg::ADDR_W-1:0]  col_r, col_nxt;
  logic [1:0]                  rows_r, rows_nxt;
  logic                        draining_r, draining_nxt;
  logic [hnm_pkg::HEIGHT_W-1:0] left_r;

  logic [hnm_pkg::WIDTH_W-1:0]  w_eff;
  logic                         last;
  logic                         is_drain;
  logic                         eff;
  logic                         emit;
  logic                         wr_en;
  logic [hnm_pkg::ADDR_W-1:0]   raddr;
  hnm_pkg::col_pair_t           wdata;
  logic [hnm_pkg::HEIGHT_W-1:0] ctr, up, lft, down;

  always_comb begin
    if (width_r == '0) begin
      w_eff = hnm_pkg::WIDTH_W'(1);
    end else if (width_r > hnm_pkg::WIDTH_W'(hnm_pkg::MAX_WIDTH)) begin
      w_eff = hnm_pkg::WIDTH_W'(hnm_pkg::MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    last     = (hnm_pkg::WIDTH_W'(col_r) + hnm_pkg::WIDTH_W'(1)) >= w_eff;
    is_drain = (in_word.operation == hnm_pkg::OP_DRAIN);
    // a drain counts only with a row stored and at a row start or mid-drain;
    // pixels are dropped while draining
    if (is_drain) begin
      eff = acc && (rows_r != 2'd0) && ((col_r == '0) || draining_r);
    end else begin
      eff = acc && !draining_r;
    end
    emit = eff && (is_drain || (rows_r != 2'd0));

    ctr  = rdata_r.center;
    up   = (rows_r >= 2'd2) ? rdata_r.upper : ctr;   // top output row clamps
    lft  = (col_r == '0) ? ctr : left_r;             // left border clamps
    down = is_drain ? ctr : in_word.height_sample;   // last row is its own below

    wr_en        = eff && !is_drain;
    wdata.upper  = ctr;
    wdata.center = in_word.height_sample;
    raddr        = last ? '0 : col_r + hnm_pkg::ADDR_W'(1);

    col_nxt      = col_r;
    rows_nxt     = rows_r;
    draining_nxt = draining_r;
    if (eff) begin
      if (last) begin
        col_nxt = '0;
        if (is_drain) begin
          rows_nxt     = 2'd0;
          draining_nxt = 1'b0;
        end else if (rows_r < 2'd2) begin
          rows_nxt = rows_r + 2'd1;
        end
      end else begin
        col_nxt = col_r + hnm_pkg::ADDR_W'(1);
        if (is_drain) begin
          draining_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      rows_r     <= 2'd0;
      draining_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      rows_r     <= rows_nxt;
      draining_r <= draining_nxt;
    end
  end

  // store write and prefetch; a one-column row writes and reads column 0
  // in the same cycle, so the write data is forwarded
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[col_r] <= wdata;
    end
    if (eff) begin
      rdata_r <= (wr_en && (raddr == col_r)) ? wdata : mem[raddr];
      left_r  <= ctr;
    end
  end

  // ---------------- pipeline registers ----------------
  localparam int DEPTH = 6 + hnm_pkg::J_W;
  logic [DEPTH-1:0] v_r;

  // stage 1: neighbors
  logic [hnm_pkg::HEIGHT_W-1:0] p1_ctr_r, p1_up_r, p1_lft_r, p1_down_r;
  logic                         p1_last_r;
  hnm_pkg::side_t               p1_side_r;
  // stage 2: differences
  logic signed [hnm_pkg::DIFF_W-1:0] p2_d_r, p2_e_r;
  hnm_pkg::side_t                    p2_side_r;
  // stage 3: slopes times strength
  logic [hnm_pkg::PROD_W-1:0] p3_ax_r, p3_ay_r;
  logic                       p3_negx_r, p3_negy_r;
  hnm_pkg::side_t             p3_side_r;
  // stage 4: components scaled below 2^23
  logic [hnm_pkg::COMP_W-1:0] p4_c_r [LANES];
  logic [LANES-1:0]           p4_neg_r;
  hnm_pkg::side_t             p4_side_r;
  // stage 5: squares
  logic [hnm_pkg::SQ_W-1:0]   p5_sq_r [LANES];
  logic [LANES-1:0]           p5_neg_r;
  hnm_pkg::side_t             p5_side_r;
  // stage 6 and root digit stages
  hnm_pkg::iter_t             p6_r;
  hnm_pkg::iter_t             it_r   [hnm_pkg::J_W];
  hnm_pkg::iter_t             it_nxt [hnm_pkg::J_W];
  hnm_pkg::out_word_t         out_r;

  // combinational values of each stage
  logic [hnm_pkg::HEIGHT_W-1:0]      rgt;
  logic [hnm_pkg::HEIGHT_W-1:0]      abs_d, abs_e;
  logic [hnm_pkg::PROD_W-1:0]        ormag;
  logic [hnm_pkg::SH_W-1:0]          sh;
  logic [hnm_pkg::PROD_W-1:0]        az;
  hnm_pkg::iter_t                    p6_nxt;
  logic [hnm_pkg::SQ_W+1:0]          len2;
  hnm_pkg::out_word_t                out_nxt;
  logic [hnm_pkg::CODE_W-1:0]        code [LANES];

  always_comb begin
    rgt   = p1_last_r ? p1_ctr_r : rdata_r.center;   // right border clamps
    abs_d = (p2_d_r < 0) ? hnm_pkg::HEIGHT_W'(-p2_d_r) : hnm_pkg::HEIGHT_W'(p2_d_r);
    abs_e = (p2_e_r < 0) ? hnm_pkg::HEIGHT_W'(-p2_e_r) : hnm_pkg::HEIGHT_W'(p2_e_r);

    // least right shift that brings the largest magnitude below 2^23
    ormag = p3_ax_r | p3_ay_r | hnm_pkg::Z_UNIT;
    sh    = hnm_pkg::MIN_SHIFT;
    for (int i = hnm_pkg::COMP_W + 2; i < hnm_pkg::PROD_W; i++) begin
      if (ormag[i]) sh = hnm_pkg::SH_W'(i - hnm_pkg::COMP_W + 1);
    end
    az = hnm_pkg::Z_UNIT >> sh;

    // 65025 * c^2 by shift and add, and 4 * |v|^2
    len2 = (hnm_pkg::SQ_W+2)'(p5_sq_r[0]) + (hnm_pkg::SQ_W+2)'(p5_sq_r[1])
         + (hnm_pkg::SQ_W+2)'(p5_sq_r[2]);
    p6_nxt.len4 = hnm_pkg::LEN4_W'(len2) << 2;
    p6_nxt.side = p5_side_r;
    for (int l = 0; l < LANES; l++) begin
      p6_nxt.lane[l].rem  = (hnm_pkg::REM_W'(p5_sq_r[l]) << 16)
                          - (hnm_pkg::REM_W'(p5_sq_r[l]) << 9)
                          + hnm_pkg::REM_W'(p5_sq_r[l]);
      p6_nxt.lane[l].yacc = '0;
      p6_nxt.lane[l].j    = '0;
      p6_nxt.lane[l].neg  = p5_neg_r[l];
    end

    // final codes: 128 + floor(v/2) for a positive component,
    // 128 - ceil(v/2) for a negative one, v = 255 * |c| / |vector|
    for (int l = 0; l < LANES; l++) begin
      if (it_r[hnm_pkg::J_W-1].lane[l].neg) begin
        code[l] = hnm_pkg::CODE_MID
                - hnm_pkg::CODE_W'(it_r[hnm_pkg::J_W-1].lane[l].j)
                - hnm_pkg::CODE_W'(it_r[hnm_pkg::J_W-1].lane[l].rem != '0);
      end else begin
        code[l] = hnm_pkg::CODE_MID + hnm_pkg::CODE_W'(it_r[hnm_pkg::J_W-1].lane[l].j);
      end
    end
    out_nxt.red       = code[0];
    out_nxt.green     = code[1];
    out_nxt.blue      = code[2];
    out_nxt.row_end   = it_r[hnm_pkg::J_W-1].side.row_end;
    out_nxt.frame_end = it_r[hnm_pkg::J_W-1].side.frame_end;
  end

  // One root digit per stage: find the largest j with 4*j^2*len2 <= 65025*c^2.
  // rem keeps 65025*c^2 - 4*len2*j^2 and yacc keeps 4*len2*j, so a trial bit b
  // costs (yacc << (b+1)) + (4*len2 << 2b).
  always_comb begin
    hnm_pkg::iter_t              src;
    logic [hnm_pkg::TRIAL_W-1:0] trial;
    for (int s = 0; s < hnm_pkg::J_W; s++) begin
      src       = (s == 0) ? p6_r : it_r[(s == 0) ? 0 : s - 1];
      it_nxt[s] = src;
      for (int l = 0; l < LANES; l++) begin
        trial = (hnm_pkg::TRIAL_W'(src.lane[l].yacc) << (hnm_pkg::J_W - s))
              + (hnm_pkg::TRIAL_W'(src.len4) << (2 * (hnm_pkg::J_W - 1 - s)));
        if (trial <= hnm_pkg::TRIAL_W'(src.lane[l].rem)) begin
          it_nxt[s].lane[l].rem  = src.lane[l].rem - hnm_pkg::REM_W'(trial);
          it_nxt[s].lane[l].yacc = src.lane[l].yacc
                                 + (hnm_pkg::YACC_W'(src.len4) << (hnm_pkg::J_W - 1 - s));
          it_nxt[s].lane[l].j[hnm_pkg::J_W - 1 - s] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v_r         <= {v_r[DEPTH-2:0], emit};
      out_valid_r <= v_r[DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_ctr_r            <= ctr;
      p1_up_r             <= up;
      p1_lft_r            <= lft;
      p1_down_r           <= down;
      p1_last_r           <= last;
      p1_side_r.row_end   <= last;
      p1_side_r.frame_end <= last && is_drain;

      p2_d_r    <= $signed({1'b0, rgt}) - $signed({1'b0, p1_lft_r});
      p2_e_r    <= $signed({1'b0, p1_down_r}) - $signed({1'b0, p1_up_r});
      p2_side_r <= p1_side_r;

      p3_ax_r   <= abs_d * strength_r;
      p3_ay_r   <= abs_e * strength_r;
      p3_negx_r <= (p2_d_r > 0);     // vector x is -dx
      p3_negy_r <= (p2_e_r > 0);
      p3_side_r <= p2_side_r;

      p4_c_r[0]   <= hnm_pkg::COMP_W'(p3_ax_r >> sh);
      p4_c_r[1]   <= hnm_pkg::COMP_W'(p3_ay_r >> sh);
      p4_c_r[2]   <= hnm_pkg::COMP_W'(az);
      p4_neg_r[0] <= p3_negx_r && ((p3_ax_r >> sh) != '0);
      p4_neg_r[1] <= p3_negy_r && ((p3_ay_r >> sh) != '0);
      p4_neg_r[2] <= 1'b0;
      p4_side_r   <= p3_side_r;

      for (int l = 0; l < LANES; l++) begin
        p5_sq_r[l] <= p4_c_r[l] * p4_c_r[l];
      end
      p5_neg_r  <= p4_neg_r;
      p5_side_r <= p4_side_r;

      p6_r <= p6_nxt;
      for (int s = 0; s < hnm_pkg::J_W; s++) begin
        it_r[s] <= it_nxt[s];
      end
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  // ---------------- assertions ----------------
  a_frame_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_r.frame_end || out_r.row_end))
    else $error("frame_end without row_end");

  a_drain_needs_row: assert property (@(posedge clk) disable iff (!rst_n)
    draining_r |-> (rows_r != 2'd0))
    else $error("draining with no stored row");

  a_drain_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (eff && is_drain && last) |=> ((rows_r == 2'd0) && !draining_r && (col_r == '0)))
    else $error("frame state not cleared after last drain");

  a_emit_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && adv) |=> v_r[0])
    else $error("emitted word lost at pipeline entry");

endmodule

`default_nettype wire
